// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, tables and round functions for the AES-128 encrypt core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int BLOCK_W    = 128;
  localparam int HALF_W     = 64;
  localparam int ROUND_W    = $clog2(NUM_ROUNDS + 1);
  localparam int ADDR_W     = 4;

  // register index codes, taken from paddr[3]
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [ROUND_W-1:0] FIRST_ROUND = ROUND_W'(1);
  localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(NUM_ROUNDS);

  typedef struct packed {
    logic start;
    logic hold;
  } aes_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aes_stat_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // indexed by round number, round 0 unused
  localparam logic [7:0] RCON [0:15] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
    8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // byte k of the block is bits [127-8k -: 8]; sub bytes then shift rows
  function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    int c;
    int r;
    t = '0;
    for (c = 0; c < 4; c++) begin
      for (r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(c*4+r) -: 8] = SBOX[s[BLOCK_W-1-8*(((c+r)&3)*4+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;
    logic [7:0] all;
    a0  = w[31:24];
    a1  = w[23:16];
    a2  = w[15:8];
    a3  = w[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
            a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    int c;
    t = '0;
    for (c = 0; c < 4; c++) begin
      t[BLOCK_W-1-32*c -: 32] = mix_col(s[BLOCK_W-1-32*c -: 32]);
    end
    return t;
  endfunction

  // one step of the key schedule: round key r-1 to round key r
  function automatic logic [BLOCK_W-1:0] next_key(input logic [BLOCK_W-1:0] rk,
                                                  input logic [7:0] rc);
    logic [31:0] w3;
    logic [31:0] t;
    logic [31:0] n0;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] n3;
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]} ^ {rc, 24'h0};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

`default_nettype wire

// ===== sv/aes_round_engine.sv =====
// ----------------------------------------------------------------------------
// aes_round_engine
// Iterative AES-128 datapath: one round and one key schedule step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire aes_pkg::aes_ctl_t             ctl,
  input  wire logic [aes_pkg::BLOCK_W-1:0]   key,
  input  wire logic [aes_pkg::BLOCK_W-1:0]   plain,
  output aes_pkg::aes_stat_t                 stat,
  output logic [aes_pkg::BLOCK_W-1:0]        result
);
  import aes_pkg::*;

  logic                 busy;
  logic [ROUND_W-1:0]   round;
  logic [BLOCK_W-1:0]   st;
  logic [BLOCK_W-1:0]   rk;
  logic [BLOCK_W-1:0]   rk_next;
  logic [BLOCK_W-1:0]   shifted;
  logic                 last;

  assign rk_next = next_key(rk, RCON[round]);
  assign shifted = sub_shift(st);
  assign last    = (round == LAST_ROUND);

  // last round skips mix columns
  assign result    = shifted ^ rk_next;
  assign stat.busy = busy;
  assign stat.done = busy && last && !ctl.hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      if (ctl.start) begin
        busy <= 1'b1;
      end
    end else if (stat.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      // key whitening on entry
      st    <= plain ^ key;
      rk    <= key;
      round <= FIRST_ROUND;
    end else if (!last) begin
      st    <= mix_columns(shifted) ^ rk_next;
      rk    <= rk_next;
      round <= round + ROUND_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/aes128_block_encrypt_core.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core
// AES-128 block encryption with an APB key port and valid/stall channels.
// ----------------------------------------------------------------------------
// Each input item is one 128-bit plaintext block, encrypted with AES-128 under
// the key in key_high (offset 0x0) and key_low (offset 0x8); one ciphertext
// item comes out per block. The accept cycle applies round key 0; the shared
// round unit then runs one round per cycle, deriving each round key on the
// fly from the previous one, and holds the last round while the output
// register is stalled. The input stalls while a block is in flight; the
// finished ciphertext sits in an output register, so the next block can be
// accepted while it waits. The key may only be changed while the core is idle.
`default_nettype none

module aes128_block_encrypt_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [aes_pkg::HALF_W-1:0]    plain_high,
  input  wire logic [aes_pkg::HALF_W-1:0]    plain_low,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [aes_pkg::HALF_W-1:0]         cipher_high,
  output logic [aes_pkg::HALF_W-1:0]         cipher_low,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aes_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [aes_pkg::HALF_W-1:0]    pwdata,
  output logic [aes_pkg::HALF_W-1:0]         prdata,
  output logic                               pready
);
  import aes_pkg::*;

  logic [HALF_W-1:0]  key_high;
  logic [HALF_W-1:0]  key_low;
  logic               cfg_wr;
  aes_ctl_t           eng_ctl;
  aes_stat_t          eng_stat;
  logic [BLOCK_W-1:0] eng_result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low : key_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
        default:      key_high <= key_high;
      endcase
    end
  end

  assign in_stall      = eng_stat.busy;
  assign eng_ctl.start = in_valid;
  // finished block waits in the engine while the output register is full and stalled
  assign eng_ctl.hold  = out_valid && out_stall;

  aes_round_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctl    (eng_ctl),
    .key    ({key_high, key_low}),
    .plain  ({plain_high, plain_low}),
    .stat   (eng_stat),
    .result (eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_stat.done) begin
      cipher_high <= eng_result[BLOCK_W-1:HALF_W];
      cipher_low  <= eng_result[HALF_W-1:0];
    end
  end

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    eng_stat.done |=> out_valid)
    else $error("finished block did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !eng_stat.done)
    else $error("output register overwritten while stalled");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (eng_stat.busy && !eng_stat.done))
    else $error("accepted item did not start the round engine");

  a_stalled_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cipher_high) && $stable(cipher_low)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
